>>> hdl/tqc_pkg.sv
// Shared widths, screen constant and inter-stage types for the quad coverage pipeline.
// No dependencies; every other file of the block imports this package.
package tqc_pkg;

  // Field widths
  localparam int COORD_W   = 14;
  localparam int QUAD_W    = 12;
  localparam int NPIX      = 4;

  // Arithmetic widths: differences, products, cross terms, steps, per-pixel terms, sums
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int STEP_W    = DIFF_W + 1;
  localparam int PIX_W     = CROSS_W + 1;
  localparam int SUM_W     = PIX_W + 1;

  // Screen bound and the width used to compare pixel positions against it
  localparam int SCREEN_SIZE = 4096;
  localparam int SCR_W       = 16;

  // Stream payload widths
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 8;

  // Products and edge vectors leaving the setup stages
  typedef struct packed {
    logic signed [PROD_W-1:0] p_u1v2;
    logic signed [PROD_W-1:0] p_u2v1;
    logic signed [PROD_W-1:0] p_u2v0;
    logic signed [PROD_W-1:0] p_u0v2;
    logic signed [PROD_W-1:0] p_u0v1;
    logic signed [PROD_W-1:0] p_u1v0;
    logic signed [DIFF_W-1:0] u0;
    logic signed [DIFF_W-1:0] u1;
    logic signed [DIFF_W-1:0] v0;
    logic signed [DIFF_W-1:0] v1;
    logic [NPIX-1:0]          onscr;
  } tqc_prod_t;

  // Per-pixel cross terms leaving the edge stages
  typedef struct packed {
    logic [NPIX-1:0][PIX_W-1:0] c0k;
    logic [NPIX-1:0][PIX_W-1:0] c1k;
    logic signed [CROSS_W-1:0]  c2;
    logic                       degen;
    logic [NPIX-1:0]            onscr;
  } tqc_edge_t;

endpackage

>>> hdl/tqc_setup.sv
// Setup stages: edge vector differences, screen bound flags, then the six cross products.
// Depends on tqc_pkg.
module tqc_setup import tqc_pkg::*; (
  input  logic                       clk_i,
  input  logic [1:0]                 en_i,
  input  logic signed [COORD_W-1:0]  vertex0_x_i,
  input  logic signed [COORD_W-1:0]  vertex0_y_i,
  input  logic signed [COORD_W-1:0]  vertex1_x_i,
  input  logic signed [COORD_W-1:0]  vertex1_y_i,
  input  logic signed [COORD_W-1:0]  vertex2_x_i,
  input  logic signed [COORD_W-1:0]  vertex2_y_i,
  input  logic [QUAD_W-1:0]          quad_x_i,
  input  logic [QUAD_W-1:0]          quad_y_i,
  output tqc_prod_t                  prod_o
);

  logic signed [DIFF_W-1:0] u0_d, u1_d, v0_d, v1_d, u2_d, v2_d;
  logic signed [DIFF_W-1:0] u0_q, u1_q, v0_q, v1_q, u2_q, v2_q;
  logic [NPIX-1:0]          onscr_d, onscr_q;
  logic [SCR_W-1:0]         px_w [NPIX];
  logic [SCR_W-1:0]         py_w [NPIX];
  tqc_prod_t                prod_d, prod_q;

  // Form edge vectors relative to vertex 0 and the quad origin
  always_comb begin
    u0_d = {vertex1_x_i[COORD_W-1], vertex1_x_i} - {vertex0_x_i[COORD_W-1], vertex0_x_i};
    u1_d = {vertex2_x_i[COORD_W-1], vertex2_x_i} - {vertex0_x_i[COORD_W-1], vertex0_x_i};
    v0_d = {vertex1_y_i[COORD_W-1], vertex1_y_i} - {vertex0_y_i[COORD_W-1], vertex0_y_i};
    v1_d = {vertex2_y_i[COORD_W-1], vertex2_y_i} - {vertex0_y_i[COORD_W-1], vertex0_y_i};
    u2_d = {vertex0_x_i[COORD_W-1], vertex0_x_i}
         - $signed({{(DIFF_W-QUAD_W){1'b0}}, quad_x_i});
    v2_d = {vertex0_y_i[COORD_W-1], vertex0_y_i}
         - $signed({{(DIFF_W-QUAD_W){1'b0}}, quad_y_i});
  end

  // Flag pixels of the quad that lie on screen
  always_comb begin
    for (int k = 0; k < NPIX; k++) begin
      px_w[k]    = SCR_W'(quad_x_i) + SCR_W'(k & 1);
      py_w[k]    = SCR_W'(quad_y_i) + SCR_W'((k >> 1) & 1);
      onscr_d[k] = (px_w[k] < SCR_W'(SCREEN_SIZE)) && (py_w[k] < SCR_W'(SCREEN_SIZE));
    end
  end

  // Stage A: hold differences
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u0_q    <= u0_d;
      u1_q    <= u1_d;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
      u2_q    <= u2_d;
      v2_q    <= v2_d;
      onscr_q <= onscr_d;
    end
  end

  // Multiply the cross product terms
  always_comb begin
    prod_d.p_u1v2 = PROD_W'(u1_q) * PROD_W'(v2_q);
    prod_d.p_u2v1 = PROD_W'(u2_q) * PROD_W'(v1_q);
    prod_d.p_u2v0 = PROD_W'(u2_q) * PROD_W'(v0_q);
    prod_d.p_u0v2 = PROD_W'(u0_q) * PROD_W'(v2_q);
    prod_d.p_u0v1 = PROD_W'(u0_q) * PROD_W'(v1_q);
    prod_d.p_u1v0 = PROD_W'(u1_q) * PROD_W'(v0_q);
    prod_d.u0     = u0_q;
    prod_d.u1     = u1_q;
    prod_d.v0     = v0_q;
    prod_d.v1     = v1_q;
    prod_d.onscr  = onscr_q;
  end

  // Stage B: hold products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> hdl/tqc_edge.sv
// Edge stages: cross terms at the quad origin, then stepped to each of the four pixels.
// Depends on tqc_pkg.
module tqc_edge import tqc_pkg::*; (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  tqc_prod_t   prod_i,
  output tqc_edge_t   edge_o
);

  logic signed [CROSS_W-1:0] c0_d, c1_d, c2_d, c0_q, c1_q, c2_q;
  logic signed [STEP_W-1:0]  s0x_d, s0y_d, s0xy_d, s1x_d, s1y_d, s1xy_d;
  logic signed [STEP_W-1:0]  s0x_q, s0y_q, s0xy_q, s1x_q, s1y_q, s1xy_q;
  logic signed [STEP_W-1:0]  u0_e, u1_e, v0_e, v1_e;
  logic signed [PIX_W-1:0]   c0_e, c1_e;
  logic [NPIX-1:0]           onscr_q;
  tqc_edge_t                 edge_d, edge_q;

  // Combine product pairs into cross terms; form per-pixel step sizes
  always_comb begin
    c0_d   = {prod_i.p_u1v2[PROD_W-1], prod_i.p_u1v2} - {prod_i.p_u2v1[PROD_W-1], prod_i.p_u2v1};
    c1_d   = {prod_i.p_u2v0[PROD_W-1], prod_i.p_u2v0} - {prod_i.p_u0v2[PROD_W-1], prod_i.p_u0v2};
    c2_d   = {prod_i.p_u0v1[PROD_W-1], prod_i.p_u0v1} - {prod_i.p_u1v0[PROD_W-1], prod_i.p_u1v0};
    u0_e   = {prod_i.u0[DIFF_W-1], prod_i.u0};
    u1_e   = {prod_i.u1[DIFF_W-1], prod_i.u1};
    v0_e   = {prod_i.v0[DIFF_W-1], prod_i.v0};
    v1_e   = {prod_i.v1[DIFF_W-1], prod_i.v1};
    // c0 gains v1 per +x and loses u1 per +y; c1 loses v0 per +x and gains u0 per +y
    s0x_d  = v1_e;
    s0y_d  = -u1_e;
    s0xy_d = v1_e - u1_e;
    s1x_d  = -v0_e;
    s1y_d  = u0_e;
    s1xy_d = u0_e - v0_e;
  end

  // Stage C: hold origin cross terms and steps
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      s0x_q   <= s0x_d;
      s0y_q   <= s0y_d;
      s0xy_q  <= s0xy_d;
      s1x_q   <= s1x_d;
      s1y_q   <= s1y_d;
      s1xy_q  <= s1xy_d;
      onscr_q <= prod_i.onscr;
    end
  end

  // Step the origin terms to each pixel
  always_comb begin
    c0_e          = {c0_q[CROSS_W-1], c0_q};
    c1_e          = {c1_q[CROSS_W-1], c1_q};
    edge_d.c0k[0] = c0_e;
    edge_d.c0k[1] = c0_e + PIX_W'(s0x_q);
    edge_d.c0k[2] = c0_e + PIX_W'(s0y_q);
    edge_d.c0k[3] = c0_e + PIX_W'(s0xy_q);
    edge_d.c1k[0] = c1_e;
    edge_d.c1k[1] = c1_e + PIX_W'(s1x_q);
    edge_d.c1k[2] = c1_e + PIX_W'(s1y_q);
    edge_d.c1k[3] = c1_e + PIX_W'(s1xy_q);
    edge_d.c2     = c2_q;
    edge_d.degen  = (c2_q == '0);
    edge_d.onscr  = onscr_q;
  end

  // Stage D: hold per-pixel terms
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      edge_q <= edge_d;
    end
  end

  assign edge_o = edge_q;

endmodule

>>> hdl/tqc_test.sv
// Test stages: sign checks and the third barycentric bound per pixel, then the result register.
// Depends on tqc_pkg.
module tqc_test import tqc_pkg::*; (
  input  logic             clk_i,
  input  logic [1:0]       en_i,
  input  tqc_edge_t        edge_i,
  output logic [NPIX-1:0]  coverage_mask_o,
  output logic             any_covered_o,
  output logic             degenerate_o
);

  logic signed [PIX_W-1:0] c0_w [NPIX];
  logic signed [PIX_W-1:0] c1_w [NPIX];
  logic signed [SUM_W-1:0] sum_d [NPIX];
  logic signed [SUM_W-1:0] sum_q [NPIX];
  logic [NPIX-1:0]         sign_ok_d, sign_ok_q;
  logic signed [CROSS_W-1:0] c2_q;
  logic                    c2_neg;
  logic                    degen_q;
  logic [NPIX-1:0]         onscr_q;
  logic signed [SUM_W-1:0] c2_e;
  logic [NPIX-1:0]         third_w;
  logic [NPIX-1:0]         mask_d, mask_q;
  logic                    any_q, degen_out_q;

  // Sum the first two terms; check both ratios share the sign of c2 or are zero
  always_comb begin
    c2_neg = edge_i.c2[CROSS_W-1];
    for (int k = 0; k < NPIX; k++) begin
      c0_w[k]      = $signed(edge_i.c0k[k]);
      c1_w[k]      = $signed(edge_i.c1k[k]);
      sum_d[k]     = {c0_w[k][PIX_W-1], c0_w[k]} + {c1_w[k][PIX_W-1], c1_w[k]};
      sign_ok_d[k] = c2_neg ? ((c0_w[k] <= 0) && (c1_w[k] <= 0))
                            : ((c0_w[k] >= 0) && (c1_w[k] >= 0));
    end
  end

  // Stage E: hold sums and sign results
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sum_q     <= sum_d;
      sign_ok_q <= sign_ok_d;
      c2_q      <= edge_i.c2;
      degen_q   <= edge_i.degen;
      onscr_q   <= edge_i.onscr;
    end
  end

  // Bound the sum by c2 in the direction of its sign; combine into the mask
  always_comb begin
    c2_e = {{(SUM_W-CROSS_W){c2_q[CROSS_W-1]}}, c2_q};
    for (int k = 0; k < NPIX; k++) begin
      third_w[k] = c2_q[CROSS_W-1] ? (sum_q[k] >= c2_e) : (sum_q[k] <= c2_e);
    end
    mask_d = sign_ok_q & third_w & onscr_q & {NPIX{~degen_q}};
  end

  // Stage F: output register
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mask_q      <= mask_d;
      any_q       <= |mask_d;
      degen_out_q <= degen_q;
    end
  end

  assign coverage_mask_o = mask_q;
  assign any_covered_o   = any_q;
  assign degenerate_o    = degen_out_q;

endmodule

>>> hdl/triangle_quad_coverage.sv
// Channel   Dir  Width  Contents (low bit first)
// s_axis    in   112    vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
//                       quad_x, quad_y, zero pad
// m_axis    out  8      coverage_mask, any_covered, degenerate, zero pad
//
// One quad enters per cycle unless m_axis stalls; each result passes through the setup,
// product, cross-term, pixel-step, sign and bound stages, the last being the output register.
// Reset clears only the stage valid bits. A stall on m_axis holds full stages in place;
// each stage still loads while it is empty, so bubbles close up before s_axis stalls.
// Top level of the triangle quad coverage test; depends on tqc_pkg, tqc_setup, tqc_edge,
// tqc_test.
module triangle_quad_coverage import tqc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // v0x, v0y, v1x, v1y, v2x, v2y, quad_x, quad_y
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // coverage_mask, any_covered, degenerate
);

  localparam int NSTAGE = 6;

  logic [NSTAGE-1:0] vld_d, vld_q;
  logic [NSTAGE-1:0] en;
  tqc_prod_t         prod;
  tqc_edge_t         edge_terms;
  logic [NPIX-1:0]   coverage_mask;
  logic              any_covered;
  logic              degenerate;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTAGE-1] = ~vld_q[NSTAGE-1] | m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  // Move valid bits along with the data
  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  tqc_setup u_setup (
    .clk_i       (clk_i),
    .en_i        (en[1:0]),
    .vertex0_x_i (s_axis_tdata[13:0]),
    .vertex0_y_i (s_axis_tdata[27:14]),
    .vertex1_x_i (s_axis_tdata[41:28]),
    .vertex1_y_i (s_axis_tdata[55:42]),
    .vertex2_x_i (s_axis_tdata[69:56]),
    .vertex2_y_i (s_axis_tdata[83:70]),
    .quad_x_i    (s_axis_tdata[95:84]),
    .quad_y_i    (s_axis_tdata[107:96]),
    .prod_o      (prod)
  );

  tqc_edge u_edge (
    .clk_i  (clk_i),
    .en_i   (en[3:2]),
    .prod_i (prod),
    .edge_o (edge_terms)
  );

  tqc_test u_test (
    .clk_i           (clk_i),
    .en_i            (en[5:4]),
    .edge_i          (edge_terms),
    .coverage_mask_o (coverage_mask),
    .any_covered_o   (any_covered),
    .degenerate_o    (degenerate)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NSTAGE-1];
  assign m_axis_tdata  = {2'b00, degenerate, any_covered, coverage_mask};

endmodule

>>> hdl/tqc_checker.sv
// Port-level checks of the quad coverage block, attached to the top level by bind.
// Depends on tqc_pkg and triangle_quad_coverage.
module tqc_checker import tqc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tready,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata   // coverage_mask, any_covered, degenerate
);

  // Any-covered flag agrees with the mask
  a_any_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tdata[3:0] != 4'h0)))
    else $error("any_covered disagrees with coverage_mask");

  // A degenerate triangle covers nothing
  a_degen_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[3:0] == 4'h0))
    else $error("degenerate result with nonzero coverage");

  // With the output empty the pipeline must take input
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind triangle_quad_coverage tqc_checker u_tqc_checker (.*);

>>> sim/tb_triangle_quad_coverage.sv
// Self-checking testbench for triangle_quad_coverage: directed table, then randomized quads.
// Each transfer is checked against a local coverage predictor. Depends on tqc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_triangle_quad_coverage;
  import tqc_pkg::*;

  localparam int RANDOM_ITEMS     = 1430;
  localparam int QUIET_ITEMS      = 150;
  localparam int PAUSE_AT_ITEM    = 700;
  localparam int LONG_HOLD_AT     = 1000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 20;
  localparam int COORD_MIN        = -8192;
  localparam int COORD_MAX        = 8191;

  // One quad request as the block sees it
  typedef struct packed {
    logic signed [COORD_W-1:0] v0x;
    logic signed [COORD_W-1:0] v0y;
    logic signed [COORD_W-1:0] v1x;
    logic signed [COORD_W-1:0] v1y;
    logic signed [COORD_W-1:0] v2x;
    logic signed [COORD_W-1:0] v2y;
    logic [QUAD_W-1:0]         qx;
    logic [QUAD_W-1:0]         qy;
  } quad_req_t;

  // One coverage answer
  typedef struct packed {
    logic [NPIX-1:0] mask;
    logic            hit;
    logic            degen;
  } coverage_t;

  // Directed stimulus row; a typed answer is used only where it is obvious
  typedef struct {
    quad_req_t req;
    bit        typed;
    coverage_t cov;
  } quad_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // v0x, v0y, v1x, v1y, v2x, v2y, quad_x, quad_y, pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // coverage_mask, any_covered, degenerate, pad

  coverage_t coverage_expected[$];
  int        mismatch_count;
  int        quads_sent;
  int        quads_hit;
  int        quads_full;
  int        quads_degen;
  bit        quiet_phase;

  triangle_quad_coverage u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact edge-function coverage of the four quad pixels
  function automatic coverage_t predict_coverage(quad_req_t q);
    longint x0, y0, x1, y1, x2, y2;
    longint px, py, u0, u1, u2, v0, v1, v2, c0, c1, c2, s;
    bit covered;
    coverage_t r;
    x0 = longint'(q.v0x); y0 = longint'(q.v0y);
    x1 = longint'(q.v1x); y1 = longint'(q.v1y);
    x2 = longint'(q.v2x); y2 = longint'(q.v2y);
    u0 = x1 - x0; u1 = x2 - x0;
    v0 = y1 - y0; v1 = y2 - y0;
    c2 = u0 * v1 - u1 * v0;
    r = '0;
    r.degen = (c2 == 0);
    if (!r.degen) begin
      for (int k = 0; k < NPIX; k++) begin
        px = longint'(q.qx) + longint'(k & 1);
        py = longint'(q.qy) + longint'((k >> 1) & 1);
        if (px >= longint'(SCREEN_SIZE) || py >= longint'(SCREEN_SIZE)) continue;
        u2 = x0 - px;
        v2 = y0 - py;
        c0 = u1 * v2 - u2 * v1;
        c1 = u2 * v0 - u0 * v2;
        s  = c0 + c1;
        // zero ratios sit on an edge and count as covered
        covered = (c0 == 0 || ((c0 > 0) == (c2 > 0))) &&
                  (c1 == 0 || ((c1 > 0) == (c2 > 0))) &&
                  ((c2 > 0) ? (s <= c2) : (s >= c2));
        r.mask[k] = covered;
      end
    end
    r.hit = |r.mask;
    return r;
  endfunction

  function automatic quad_row_t row(int x0, int y0, int x1, int y1, int x2, int y2,
                                    int qx, int qy, bit typed = 1'b0,
                                    int mask = 0, bit hit = 1'b0, bit degen = 1'b0);
    quad_row_t r;
    r.req.v0x = COORD_W'(x0); r.req.v0y = COORD_W'(y0);
    r.req.v1x = COORD_W'(x1); r.req.v1y = COORD_W'(y1);
    r.req.v2x = COORD_W'(x2); r.req.v2y = COORD_W'(y2);
    r.req.qx  = QUAD_W'(qx);  r.req.qy  = QUAD_W'(qy);
    r.typed     = typed;
    r.cov.mask  = NPIX'(mask);
    r.cov.hit   = hit;
    r.cov.degen = degen;
    return r;
  endfunction

  function automatic int near(int base, int span);
    return base + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 2))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return int'($urandom_range(0, 16383)) - 8192;
    endcase
  endfunction

  // Offer one quad, with an optional idle burst ahead of it; record the answer on transfer
  task automatic send_quad(quad_req_t q, coverage_t cov);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'b0, q.qy, q.qx, q.v2y, q.v2x, q.v1y, q.v1x, q.v0y, q.v0x};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    coverage_expected.push_back(cov);
    quads_sent++;
  endtask

  // Receiver: random stall bursts, one long hold-off to back up the pipeline
  initial begin : receiver
    int cycle_count;
    int gap;
    bit long_hold_done;
    cycle_count    = 0;
    long_hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && cycle_count >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        cycle_count += LONG_HOLD_CYCLES;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        cycle_count += gap;
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
        cycle_count++;
      end
    end
  end

  // Compare each output transfer with the oldest pending answer
  always @(posedge clk_i) begin : result_check
    coverage_t got;
    coverage_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mask  = m_axis_tdata[3:0];
      got.hit   = m_axis_tdata[4];
      got.degen = m_axis_tdata[5];
      if (coverage_expected.size() == 0) begin
        $display("%0t: unexpected result mask=%h any=%b degenerate=%b",
                 $time, got.mask, got.hit, got.degen);
        mismatch_count++;
      end else begin
        want = coverage_expected.pop_front();
        if (got.mask !== want.mask) begin
          $display("%0t: coverage_mask expected %h actual %h", $time, want.mask, got.mask);
          mismatch_count++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: any_covered expected %b actual %b", $time, want.hit, got.hit);
          mismatch_count++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
          mismatch_count++;
        end
      end
      if (got.hit) quads_hit++;
      if (got.mask == 4'hF) quads_full++;
      if (got.degen) quads_degen++;
    end
  end

  // Stimulus: reset, directed table, random quads, drain, verdict
  initial begin : stimulus
    quad_row_t directed_rows[$];
    quad_req_t q;
    int mode, bx, by, x0, y0, dx, dy, m;
    mismatch_count = 0;
    quads_sent     = 0;
    quads_hit      = 0;
    quads_full     = 0;
    quads_degen    = 0;
    quiet_phase    = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all vertices at the origin, first transfer after reset
    directed_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
    // collinear along the diagonal at the coordinate extremes
    directed_rows.push_back(row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0,
                                4095, 4095, 1, 0, 0, 1));
    // huge triangle covering the whole screen
    directed_rows.push_back(row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MAX, 0, 0, 1, 15, 1, 0));
    // same triangle, quads clipped by the right and bottom screen edges
    directed_rows.push_back(row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MAX, 4095, 4095, 1, 1, 1, 0));
    directed_rows.push_back(row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MAX, 4095, 0, 1, 5, 1, 0));
    directed_rows.push_back(row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MAX, 0, 4095, 1, 3, 1, 0));
    // reversed winding
    directed_rows.push_back(row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                                COORD_MIN, 100, 200, 1, 15, 1, 0));
    // unit triangle with three pixels on its vertices
    directed_rows.push_back(row(10, 10, 11, 10, 10, 11, 10, 10, 1, 7, 1, 0));
    // triangle entirely at negative coordinates
    directed_rows.push_back(row(-100, -100, -50, -100, -100, -50, 0, 0, 1, 0, 0, 0));
    // vertex on an off-screen pixel of the quad
    directed_rows.push_back(row(4096, 4096, 4200, 4096, 4096, 4200, 4095, 4095, 1, 0, 0, 0));
    // horizontal collinear vertices
    directed_rows.push_back(row(0, 5, 100, 5, COORD_MAX, 5, 50, 5, 1, 0, 0, 1));
    // repeated vertex
    directed_rows.push_back(row(300, 400, 300, 400, 900, 17, 300, 400, 1, 0, 0, 1));
    // pixels on edges and on the long edge
    directed_rows.push_back(row(0, 0, 4, 0, 0, 4, 2, 0));
    directed_rows.push_back(row(0, 0, 0, 4, 4, 0, 2, 2));
    // thin sliver through the quad
    directed_rows.push_back(row(0, 0, 4095, 4094, 4095, 4095, 2000, 2000));
    // field extremes
    directed_rows.push_back(row(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                COORD_MAX, 4095, 0));
    directed_rows.push_back(row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                COORD_MIN, 4095, 4095));
    directed_rows.push_back(row(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MIN, 0, 0));
    // small clockwise triangle straddling the quad
    directed_rows.push_back(row(1000, 1000, 999, 1003, 1003, 999, 1000, 1000));

    foreach (directed_rows[i]) begin
      send_quad(directed_rows[i].req,
                directed_rows[i].typed ? directed_rows[i].cov
                                       : predict_coverage(directed_rows[i].req));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      // hold the sender until the pipeline has fully drained
      if (n == PAUSE_AT_ITEM) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (coverage_expected.size() != 0) @(posedge clk_i);
      end
      mode = $urandom_range(0, 9);
      if (mode == 7) begin
        q.qx = QUAD_W'(4088 + $urandom_range(0, 7));
        q.qy = QUAD_W'($urandom_range(0, 1) ? 4088 + $urandom_range(0, 7)
                                            : $urandom_range(0, 4095));
      end else begin
        q.qx = QUAD_W'($urandom());
        q.qy = QUAD_W'($urandom());
      end
      bx = int'(q.qx);
      by = int'(q.qy);
      case (mode)
        0, 1: begin
          q.v0x = COORD_W'($urandom()); q.v0y = COORD_W'($urandom());
          q.v1x = COORD_W'($urandom()); q.v1y = COORD_W'($urandom());
          q.v2x = COORD_W'($urandom()); q.v2y = COORD_W'($urandom());
        end
        2, 3, 4, 5, 7: begin
          q.v0x = COORD_W'(near(bx, 12)); q.v0y = COORD_W'(near(by, 12));
          q.v1x = COORD_W'(near(bx, 12)); q.v1y = COORD_W'(near(by, 12));
          q.v2x = COORD_W'(near(bx, 12)); q.v2y = COORD_W'(near(by, 12));
        end
        6: begin
          // collinear or coincident vertices around the quad
          x0 = near(bx, 4);
          y0 = near(by, 4);
          dx = int'($urandom_range(0, 16)) - 8;
          dy = int'($urandom_range(0, 16)) - 8;
          m  = int'($urandom_range(0, 5)) - 2;
          q.v0x = COORD_W'(x0);          q.v0y = COORD_W'(y0);
          q.v1x = COORD_W'(x0 + dx);     q.v1y = COORD_W'(y0 + dy);
          q.v2x = COORD_W'(x0 + m * dx); q.v2y = COORD_W'(y0 + m * dy);
        end
        default: begin
          q.v0x = COORD_W'(extreme_coord()); q.v0y = COORD_W'(extreme_coord());
          q.v1x = COORD_W'(extreme_coord()); q.v1y = COORD_W'(extreme_coord());
          q.v2x = COORD_W'(extreme_coord()); q.v2y = COORD_W'(extreme_coord());
        end
      endcase
      send_quad(q, predict_coverage(q));
    end

    // drain and settle
    s_axis_tvalid <= 1'b0;
    while (coverage_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (coverage_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, coverage_expected.size());
      mismatch_count += coverage_expected.size();
    end

    $display("Sent %0d quads: %0d with some coverage, %0d fully covered, %0d degenerate,",
             quads_sent, quads_hit, quads_full, quads_degen);
    $display("including screen-edge clipping, edge and vertex pixels, and input/output stalls.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results pending", $time, coverage_expected.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
